// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/mbps_pkg.sv =====
package mbps_pkg;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 6;
  localparam int ADDR_W    = 64;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int CARE_W    = 32;

  // Pattern storage: four 64-bit words, 32 bytes
  localparam int PAT_BYTES = 32;
  localparam int PAT_IDX_W = 5;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH,
    REG_PATTERN_WORD_0,
    REG_PATTERN_WORD_1,
    REG_PATTERN_WORD_2,
    REG_PATTERN_WORD_3,
    REG_CARE_MASK,
    REG_BASE_ADDRESS
  } cfg_reg_t;

  // Derived settings handed from the register block to the scan logic
  typedef struct packed {
    logic [LEN_W-1:0]  eff_len;
    logic [ADDR_W-1:0] addr_base;
  } mbps_cfg_t;

endpackage

// ===== rtl/mbps_cell.sv =====
module mbps_cell
  import mbps_pkg::*;
(
  input  logic              clk,
  input  logic              shift_en,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic [BYTE_W-1:0] pat_byte,
  input  logic              care,
  input  logic              active,
  output logic [BYTE_W-1:0] byte_out,
  output logic              ok
);

  logic [BYTE_W-1:0] byte_r;

  // Window slot: takes byte_in (the neighbor's byte, or the new byte in cell 0) on every transfer
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // The byte arriving now is this slot's new content
  assign ok = !active || !care || (byte_in == pat_byte);

endmodule

// ===== rtl/mbps_cfg.sv =====
module mbps_cfg
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [CFG_W-1:0]                   cfg_wdata,
  output mbps_cfg_t                          cfg_view,
  output logic [PATTERN_MAX-1:0][BYTE_W-1:0] al_byte,
  output logic [PATTERN_MAX-1:0]             al_care,
  output logic [PATTERN_MAX-1:0]             al_active
);

  logic [LEN_W-1:0]            len_r;
  logic [PAT_BYTES*BYTE_W-1:0] pattern_r;
  logic [CARE_W-1:0]           care_r;
  logic [ADDR_W-1:0]           base_r;
  logic [LEN_W-1:0]            eff_len;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_W'(1);
      pattern_r <= '0;
      care_r    <= '0;
      base_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LENGTH: len_r              <= cfg_wdata[LEN_W-1:0];
        REG_PATTERN_WORD_0: pattern_r[63:0]    <= cfg_wdata;
        REG_PATTERN_WORD_1: pattern_r[127:64]  <= cfg_wdata;
        REG_PATTERN_WORD_2: pattern_r[191:128] <= cfg_wdata;
        REG_PATTERN_WORD_3: pattern_r[255:192] <= cfg_wdata;
        REG_CARE_MASK:      care_r             <= cfg_wdata[CARE_W-1:0];
        REG_BASE_ADDRESS:   base_r             <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp length to 1..PATTERN_MAX
  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > LEN_W'(PATTERN_MAX)) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = len_r;
    end
  end

  // Address of match start = base - (len - 1) + position of newest byte
  assign cfg_view.eff_len   = eff_len;
  assign cfg_view.addr_base = base_r - ADDR_W'(eff_len - LEN_W'(1));

  // Align pattern to window slots: slot p holds pattern byte len-1-p
  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_align
    logic [LEN_W-1:0] k;
    assign k            = eff_len - LEN_W'(p + 1);
    assign al_active[p] = LEN_W'(p) < eff_len;
    assign al_byte[p]   = pattern_r[{k[PAT_IDX_W-1:0], 3'b000} +: BYTE_W];
    assign al_care[p]   = care_r[k[PAT_IDX_W-1:0]];
  end

endmodule

// ===== rtl/masked_byte_pattern_scan.sv =====
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   in_data_byte, in_stream_start
// out_      output     out_valid/out_stall out_hit_address
// cfg_      input      cfg_we              cfg_index, cfg_wdata
//
// One byte per cycle unless stalled; a hit is on out_ in the cycle after its byte.
// The window is a row of PATTERN_MAX byte cells shifted on every transfer;
// all cells compare in parallel against the aligned pattern in that cycle.
// A single output register holds the hit; in_stall rises only while it is full
// and stalled. Synchronous active-low reset clears fill, position, out_valid.
module masked_byte_pattern_scan
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_stream_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ADDR_W-1:0]    out_hit_address,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  mbps_cfg_t                          cfg_view;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] al_byte;
  logic [PATTERN_MAX-1:0]             al_care;
  logic [PATTERN_MAX-1:0]             al_active;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0] cell_byte;
  logic [PATTERN_MAX-1:0]             cell_ok;

  logic              accept;
  logic [LEN_W-1:0]  fill_r, fill_nxt, fill_base;
  logic [ADDR_W-1:0] pos_r, pos_nxt, pos_cur;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic              hit;

  // Registers and pattern alignment
  mbps_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_view  (cfg_view),
    .al_byte   (al_byte),
    .al_care   (al_care),
    .al_active (al_active)
  );

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Window cells, newest byte in cell 0
  for (genvar p = 0; p < PATTERN_MAX; p++) begin : g_cell
    logic [BYTE_W-1:0] nb;
    if (p == 0) begin : g_head
      assign nb = in_data_byte;
    end else begin : g_body
      assign nb = cell_byte[p-1];
    end
    mbps_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .byte_in  (nb),
      .pat_byte (al_byte[p]),
      .care     (al_care[p]),
      .active   (al_active[p]),
      .byte_out (cell_byte[p]),
      .ok       (cell_ok[p])
    );
  end

  // Fill count and stream position, restarted by stream_start
  always_comb begin
    fill_base = in_stream_start ? '0 : fill_r;
    pos_cur   = in_stream_start ? '0 : pos_r;
    fill_nxt  = (fill_base < LEN_W'(PATTERN_MAX)) ? fill_base + LEN_W'(1) : fill_base;
    pos_nxt   = pos_cur + ADDR_W'(1);
  end

  assign hit = accept && (&cell_ok) && (fill_nxt >= cfg_view.eff_len);

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    if (hit) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = cfg_view.addr_base + pos_cur;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        fill_r <= fill_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r <= out_addr_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit_address = out_addr_r;

endmodule

// ===== rtl/mbps_checker.sv =====
`include "assert_macros.svh"

module mbps_checker
  import mbps_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ADDR_W-1:0] out_hit_address
);

  logic in_xfer;
  logic out_held;

  assign in_xfer  = in_valid && !in_stall;
  assign out_held = out_valid && out_stall;

  // Held result stays put
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_held, $stable(out_hit_address))

  // Input stalls only behind a full, stalled output register
  `ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_held)

  // A fresh result needs a byte transfer in the cycle before
  `ASSERT_IMPLY(a_fresh_result, clk, rst_n, out_valid && !$past(out_held), $past(in_xfer))

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit_address (out_hit_address)
);
